// ===== rtl/fut_pkg.sv =====
// Shared types for the font unicode table parser.
// Payload types for the byte, map-entry and config channels; no dependencies.
package fut_pkg;

  localparam int unsigned GLYPH_CNT_W = 17;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned GLYPH_IDX_W = 16;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       end_of_table;
  } tbl_beat_t;

  typedef struct packed {
    logic                   entry_valid;
    logic [CP_W-1:0]        codepoint;
    logic [GLYPH_IDX_W-1:0] glyph_index;
    logic                   done_res;
    logic [CP_W-1:0]        peak_codepoint;
  } map_beat_t;

  typedef logic [GLYPH_CNT_W-1:0] glyph_cnt_t;

endpackage

// ===== rtl/fut_stream_if.sv =====
// Valid/ready channel interfaces for the font unicode table parser.
// Depends on fut_pkg for the payload types.
interface fut_in_if;
  logic              valid;
  logic              ready;
  fut_pkg::tbl_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fut_out_if;
  logic              valid;
  logic              ready;
  fut_pkg::map_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fut_cfg_if;
  logic               valid;
  logic               ready;
  fut_pkg::glyph_cnt_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/font_unicode_table_parser_unit.sv =====
// Top level of the font unicode table parser: UTF-8 decoder, glyph counter, result skid.
// Depends on fut_pkg and the channel interfaces in fut_stream_if.sv.
//
// Usage:
//   tbl_i carries one table byte per beat plus an end_of_table flag.
//   map_o carries a beat for every valid decoded character (entry_valid = 1)
//   and one for the last table byte (done_res = 1, peak_codepoint final).
//   Bytes that complete nothing and are not the last produce no beat.
//   cfg_i writes glyph_count, always ready; user must write it while idle; unchecked.
// Timing:
//   One byte per cycle while the skid register is empty; the decoder state
//   updates when a byte is accepted and its result is registered in the map_o
//   output register (or the skid register). The decoder state loop holds the
//   partial codepoint, pending count and glyph counter.
// Stall:
//   map_o has an output register plus a one-beat skid register; tbl_i
//   drops ready only while the skid register holds a beat.
// Reset:
//   rst_ni clears all parse state and sets glyph_count to 256. After a
//   last byte the parse state returns to reset; glyph_count is kept.
module font_unicode_table_parser_unit #(
  parameter int unsigned MAX_GLYPHS = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fut_in_if.sink        tbl_i,
  fut_out_if.source     map_o,
  fut_cfg_if.sink       cfg_i
);

  localparam int unsigned GcW  = fut_pkg::GLYPH_CNT_W;
  localparam int unsigned CpW  = fut_pkg::CP_W;
  localparam int unsigned LimW = $clog2(MAX_GLYPHS + 1);
  localparam int unsigned CmpW = (LimW > GcW) ? LimW : GcW;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_SEP = 8'hFF;
  localparam logic [7:0] BYTE_SEQ = 8'hFE;

  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;
  localparam logic [1:0] LEN_FOUR  = 2'd0;

  localparam logic [GcW-1:0] GLYPH_CNT_RST = GcW'(256);

  function automatic logic char_ok(input logic [CpW-1:0] cp, input logic [1:0] len);
    logic ok;
    ok = 1'b1;
    if (len == LEN_TWO   && cp < CpW'(24'h80))    ok = 1'b0;
    if (len == LEN_THREE && cp < CpW'(24'h800))   ok = 1'b0;
    if (len == LEN_FOUR  && cp < CpW'(24'h10000)) ok = 1'b0;
    if (cp >= CpW'(24'hD800) && cp <= CpW'(24'hDFFF)) ok = 1'b0;
    if (cp > CpW'(24'h10FFFF)) ok = 1'b0;
    return ok;
  endfunction

  // config
  logic [GcW-1:0] glyph_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_count_q <= GLYPH_CNT_RST;
    end else if (cfg_i.valid) begin
      glyph_count_q <= cfg_i.payload;
    end
  end

  // parse state
  logic [1:0]     bytes_pending_q, bytes_pending_d;
  logic [1:0]     seq_len_q, seq_len_d;
  logic [CpW-1:0] partial_cp_q, partial_cp_d;
  logic [GcW-1:0] glyph_cnt_q, glyph_cnt_d;
  logic           skipping_q, skipping_d;
  logic           stopped_q, stopped_d;
  logic [CpW-1:0] largest_cp_q, largest_cp_d;

  // output register and skid
  logic                out_valid_q, out_valid_d;
  fut_pkg::map_beat_t  out_q, out_d;
  logic                skid_valid_q, skid_valid_d;
  fut_pkg::map_beat_t  skid_q, skid_d;

  logic                accept;
  logic                out_fire;
  logic                res_valid;
  fut_pkg::map_beat_t  res;

  logic [7:0]     b;
  logic           last;
  logic           at_limit;
  logic           emit;
  logic [CpW-1:0] cp;
  logic [CpW-1:0] cont_cp;

  assign tbl_i.ready = !skid_valid_q;
  assign accept      = tbl_i.valid && tbl_i.ready;
  assign out_fire    = out_valid_q && map_o.ready;

  assign b    = tbl_i.payload.table_byte;
  assign last = tbl_i.payload.end_of_table;

  assign at_limit = (CmpW'(glyph_cnt_q) >= CmpW'(glyph_count_q)) ||
                    (CmpW'(glyph_cnt_q) >= CmpW'(MAX_GLYPHS));
  assign cont_cp  = {partial_cp_q[CpW-7:0], b[5:0]};

  always_comb begin
    bytes_pending_d = bytes_pending_q;
    seq_len_d       = seq_len_q;
    partial_cp_d    = partial_cp_q;
    glyph_cnt_d     = glyph_cnt_q;
    skipping_d      = skipping_q;
    stopped_d       = stopped_q || at_limit;
    largest_cp_d    = largest_cp_q;
    emit            = 1'b0;
    cp              = '0;

    if (!stopped_d) begin
      if (skipping_q) begin
        if (b == BYTE_SEP) begin
          skipping_d  = 1'b0;
          glyph_cnt_d = glyph_cnt_q + GcW'(1);
        end
      end else if (bytes_pending_q != 2'd0 && b[7:6] == 2'b10) begin
        partial_cp_d    = cont_cp;
        bytes_pending_d = bytes_pending_q - 2'd1;
        if (bytes_pending_q == 2'd1 && char_ok(cont_cp, seq_len_q)) begin
          emit = 1'b1;
          cp   = cont_cp;
        end
      end else begin
        // lead position; a broken continuation drops the partial character
        if (bytes_pending_q != 2'd0) begin
          bytes_pending_d = 2'd0;
          partial_cp_d    = '0;
        end
        priority if (b == BYTE_NUL) begin
          stopped_d = 1'b1;
        end else if (b == BYTE_SEP) begin
          glyph_cnt_d = glyph_cnt_q + GcW'(1);
        end else if (b == BYTE_SEQ) begin
          skipping_d = 1'b1;
        end else if (!b[7]) begin
          emit = 1'b1;
          cp   = CpW'(b);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          partial_cp_d    = CpW'(b[4:0]);
          bytes_pending_d = 2'd1;
          seq_len_d       = LEN_TWO;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          partial_cp_d    = CpW'(b[3:0]);
          bytes_pending_d = 2'd2;
          seq_len_d       = LEN_THREE;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          partial_cp_d    = CpW'(b[2:0]);
          bytes_pending_d = 2'd3;
          seq_len_d       = LEN_FOUR;
        end else begin
          // invalid lead byte: dropped
        end
      end
    end

    if (emit && cp > largest_cp_q) begin
      largest_cp_d = cp;
    end

    res_valid          = emit || last;
    res.entry_valid    = emit;
    res.codepoint      = emit ? cp : '0;
    res.glyph_index    = emit ? glyph_cnt_d[fut_pkg::GLYPH_IDX_W-1:0] : '0;
    res.done_res       = last;
    res.peak_codepoint = largest_cp_d;

    if (last) begin
      bytes_pending_d = 2'd0;
      seq_len_d       = 2'd0;
      partial_cp_d    = '0;
      glyph_cnt_d     = '0;
      skipping_d      = 1'b0;
      stopped_d       = 1'b0;
      largest_cp_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_pending_q <= 2'd0;
      seq_len_q       <= 2'd0;
      partial_cp_q    <= '0;
      glyph_cnt_q     <= '0;
      skipping_q      <= 1'b0;
      stopped_q       <= 1'b0;
      largest_cp_q    <= '0;
    end else if (accept) begin
      bytes_pending_q <= bytes_pending_d;
      seq_len_q       <= seq_len_d;
      partial_cp_q    <= partial_cp_d;
      glyph_cnt_q     <= glyph_cnt_d;
      skipping_q      <= skipping_d;
      stopped_q       <= stopped_d;
      largest_cp_q    <= largest_cp_d;
    end
  end

  // result beat goes to the output register when it is free, else to the skid
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_d = accept && res_valid;
      out_d       = res;
    end else if (accept && res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign map_o.valid   = out_valid_q;
  assign map_o.payload = out_q;

endmodule
